>>> src/id3tsp_pkg.sv
// ----------------------------------------------------------------------------
// id3tsp_pkg
// Types and constants shared by the ID3v2 tag stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package id3tsp_pkg;

  // parser phases, one-hot
  typedef enum logic [6:0] {
    PH_HDR    = 7'b0000001,
    PH_FID    = 7'b0000010,
    PH_FSIZE  = 7'b0000100,
    PH_FFLAGS = 7'b0001000,
    PH_FDATA  = 7'b0010000,
    PH_BLANK  = 7'b0100000,
    PH_OUT    = 7'b1000000
  } phase_t;

  // byte role codes
  localparam logic [2:0] ROLE_HDR    = 3'd0;
  localparam logic [2:0] ROLE_FID    = 3'd1;
  localparam logic [2:0] ROLE_FSIZE  = 3'd2;
  localparam logic [2:0] ROLE_FFLAGS = 3'd3;
  localparam logic [2:0] ROLE_FDATA  = 3'd4;
  localparam logic [2:0] ROLE_BLANK  = 3'd5;
  localparam logic [2:0] ROLE_OUT    = 3'd6;

  // tag status codes
  localparam logic [2:0] ST_PENDING = 3'd0;
  localparam logic [2:0] ST_VALID   = 3'd1;
  localparam logic [2:0] ST_NOTAG   = 3'd2;
  localparam logic [2:0] ST_FLAGS   = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;

  // header bytes
  localparam logic [7:0] MAGIC_I      = 8'h49;
  localparam logic [7:0] MAGIC_D      = 8'h44;
  localparam logic [7:0] MAGIC_3      = 8'h33;
  localparam logic [7:0] VER_BAD      = 8'hFF;
  localparam logic [7:0] SYNCSAFE_LIM = 8'h80;
  localparam logic [7:0] VER_V3       = 8'd3;

  // header byte positions
  localparam logic [3:0] HB_I     = 4'd0;
  localparam logic [3:0] HB_D     = 4'd1;
  localparam logic [3:0] HB_3     = 4'd2;
  localparam logic [3:0] HB_MAJOR = 4'd3;
  localparam logic [3:0] HB_MINOR = 4'd4;
  localparam logic [3:0] HB_FLAGS = 4'd5;
  localparam logic [3:0] HB_SIZE0 = 4'd6;
  localparam logic [3:0] HB_LAST  = 4'd9;

  // frame header lengths
  localparam logic [3:0] LEN_V3_FIELD = 4'd4;
  localparam logic [3:0] LEN_V2_FIELD = 4'd3;
  localparam logic [3:0] LEN_FFLAGS   = 4'd2;
  localparam logic [3:0] LEN_V3_FHDR  = 4'd10;
  localparam logic [3:0] LEN_V2_FHDR  = 4'd6;

  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 96;

  function automatic logic [2:0] phase_role(input phase_t ph);
    logic [2:0] r;
    case (ph)
      PH_HDR:    r = ROLE_HDR;
      PH_FID:    r = ROLE_FID;
      PH_FSIZE:  r = ROLE_FSIZE;
      PH_FFLAGS: r = ROLE_FFLAGS;
      PH_FDATA:  r = ROLE_FDATA;
      PH_BLANK:  r = ROLE_BLANK;
      default:   r = ROLE_OUT;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/id3v2_tag_stream_parser_top.sv
// ----------------------------------------------------------------------------
// id3v2_tag_stream_parser_top
// Byte-wide ID3v2 tag header and frame tracker, one result beat per byte.
// ----------------------------------------------------------------------------
// The result beat is registered and appears the cycle after its input beat is accepted.
// Throughput: one byte per cycle unless the output stalls; parser state updates in the accepting cycle.
// Output register stalls only the input when full and not taken.
// rst is synchronous, active high, and returns the parser to the header phase.
`default_nettype none

module id3v2_tag_stream_parser_top (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  input  wire  [id3tsp_pkg::TDATA_IN_W-1:0]     s_tdata,  // [7:0] data_byte
  input  wire                                   s_tuser,  // [0] first_byte
  input  wire                                   s_tlast,  // last_byte
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  // [2:0] byte_role, [5:3] tag_status, [13:6] major_version,
  // [41:14] tag_length, [73:42] frame_length, [89:74] frame_number, rest zero
  output logic [id3tsp_pkg::TDATA_OUT_W-1:0]    m_tdata,
  output logic                                  m_tlast   // frame_end
);

  import id3tsp_pkg::*;

  localparam logic [32:0] CONS_MAX = {33{1'b1}};

  phase_t      phase;
  logic [3:0]  fbc;
  logic        header_ok;
  logic        flags_seen;
  logic [7:0]  ver;
  logic [27:0] tag_size;
  logic [32:0] consumed;
  logic [31:0] frame_size;
  logic [31:0] bytes_left;
  logic [15:0] frame_index;
  logic [2:0]  status;

  phase_t      phase_b, phase_next;
  logic [3:0]  fbc_b, fbc_next;
  logic        header_ok_b, header_ok_next;
  logic        flags_seen_b, flags_seen_next;
  logic [7:0]  ver_b, ver_next;
  logic [27:0] tag_size_b, tag_size_next;
  logic [32:0] consumed_b, consumed_next, consumed_inc;
  logic [31:0] frame_size_b, frame_size_next;
  logic [31:0] bytes_left_b, bytes_left_next;
  logic [15:0] frame_index_b, frame_index_next;
  logic [2:0]  status_b, status_next;

  logic [2:0]  role;
  logic        fend;
  logic        is_v3;
  logic [3:0]  field_len;
  logic [3:0]  fhdr_len;
  logic [3:0]  fbc_inc;
  logic [7:0]  b;
  logic        accept;

  assign b      = s_tdata[7:0];
  assign accept = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;

  // state seen by this byte, after a restart on first_byte
  always_comb begin
    if (s_tuser) begin
      phase_b       = PH_HDR;
      fbc_b         = '0;
      header_ok_b   = 1'b1;
      flags_seen_b  = 1'b0;
      ver_b         = '0;
      tag_size_b    = '0;
      consumed_b    = '0;
      frame_size_b  = '0;
      bytes_left_b  = '0;
      frame_index_b = '0;
      status_b      = ST_PENDING;
    end else begin
      phase_b       = phase;
      fbc_b         = fbc;
      header_ok_b   = header_ok;
      flags_seen_b  = flags_seen;
      ver_b         = ver;
      tag_size_b    = tag_size;
      consumed_b    = consumed;
      frame_size_b  = frame_size;
      bytes_left_b  = bytes_left;
      frame_index_b = frame_index;
      status_b      = status;
    end
  end

  assign is_v3        = (ver_b == VER_V3);
  assign field_len    = is_v3 ? LEN_V3_FIELD : LEN_V2_FIELD;
  assign fhdr_len     = is_v3 ? LEN_V3_FHDR : LEN_V2_FHDR;
  assign fbc_inc      = fbc_b + 4'd1;
  assign consumed_inc = (consumed_b != CONS_MAX) ? consumed_b + 33'd1 : consumed_b;

  always_comb begin
    phase_next       = phase_b;
    fbc_next         = fbc_b;
    header_ok_next   = header_ok_b;
    flags_seen_next  = flags_seen_b;
    ver_next         = ver_b;
    tag_size_next    = tag_size_b;
    consumed_next    = consumed_b;
    frame_size_next  = frame_size_b;
    bytes_left_next  = bytes_left_b;
    frame_index_next = frame_index_b;
    status_next      = status_b;
    role             = phase_role(phase_b);
    fend             = 1'b0;

    case (phase_b)
      PH_HDR: begin
        if (fbc_b == HB_I && b != MAGIC_I) header_ok_next = 1'b0;
        if (fbc_b == HB_D && b != MAGIC_D) header_ok_next = 1'b0;
        if (fbc_b == HB_3 && b != MAGIC_3) header_ok_next = 1'b0;
        if (fbc_b == HB_MAJOR || fbc_b == HB_MINOR) begin
          if (b >= VER_BAD) header_ok_next = 1'b0;
        end
        if (fbc_b == HB_MAJOR) ver_next = b;
        if (fbc_b == HB_FLAGS) flags_seen_next = (b != 8'd0);
        if (fbc_b >= HB_SIZE0) begin
          if (b >= SYNCSAFE_LIM) header_ok_next = 1'b0;
          tag_size_next = {tag_size_b[20:0], 7'd0} + {20'd0, b};
        end
        fbc_next = fbc_inc;
        if (fbc_b >= HB_LAST) begin
          if (!header_ok_next) begin
            status_next = ST_NOTAG;
            phase_next  = PH_OUT;
          end else if (flags_seen_next) begin
            status_next = ST_FLAGS;
            phase_next  = PH_OUT;
          end else begin
            consumed_next   = '0;
            frame_size_next = '0;
            if (tag_size_next == 28'd0) begin
              status_next = ST_VALID;
              phase_next  = PH_OUT;
            end else begin
              phase_next = PH_FID;
              fbc_next   = '0;
            end
          end
        end
      end
      PH_FID: begin
        if (fbc_b == 4'd0 && b == 8'd0) begin
          role       = ROLE_BLANK;
          phase_next = PH_BLANK;
          fbc_next   = 4'd1;
        end else begin
          if (fbc_b == 4'd0) begin
            if (consumed_b != 33'd0 && frame_index_b != 16'hFFFF)
              frame_index_next = frame_index_b + 16'd1;
            frame_size_next = '0;
          end
          consumed_next = consumed_inc;
          fbc_next      = fbc_inc;
          if (fbc_inc >= field_len) begin
            phase_next = PH_FSIZE;
            fbc_next   = '0;
          end
        end
      end
      PH_BLANK: begin
        fbc_next = fbc_inc;
        if (fbc_inc >= fhdr_len) begin
          status_next = ST_VALID;
          phase_next  = PH_OUT;
        end
      end
      PH_FSIZE: begin
        consumed_next   = consumed_inc;
        frame_size_next = {frame_size_b[23:0], b};
        fbc_next        = fbc_inc;
        if (fbc_inc >= field_len) begin
          fbc_next = '0;
          if (is_v3) begin
            phase_next = PH_FFLAGS;
          end else if (frame_size_next == 32'd0) begin
            fend = 1'b1;
          end else begin
            bytes_left_next = frame_size_next;
            phase_next      = PH_FDATA;
          end
        end
      end
      PH_FFLAGS: begin
        consumed_next = consumed_inc;
        fbc_next      = fbc_inc;
        if (fbc_inc >= LEN_FFLAGS) begin
          fbc_next = '0;
          if (frame_size_b == 32'd0) begin
            fend = 1'b1;
          end else begin
            bytes_left_next = frame_size_b;
            phase_next      = PH_FDATA;
          end
        end
      end
      PH_FDATA: begin
        consumed_next = consumed_inc;
        if (bytes_left_b != 32'd0) bytes_left_next = bytes_left_b - 32'd1;
        if (bytes_left_next == 32'd0) fend = 1'b1;
      end
      default: begin
        role       = ROLE_OUT;
        phase_next = PH_OUT;
      end
    endcase

    // frame end: next frame or tag complete
    if (fend) begin
      if (consumed_next < {5'd0, tag_size_b}) begin
        phase_next = PH_FID;
        fbc_next   = '0;
      end else begin
        status_next = ST_VALID;
        phase_next  = PH_OUT;
      end
    end

    if (s_tlast) begin
      if (status_next == ST_PENDING) status_next = ST_TRUNC;
      phase_next = PH_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR;
      fbc         <= '0;
      header_ok   <= 1'b1;
      flags_seen  <= 1'b0;
      ver         <= '0;
      tag_size    <= '0;
      consumed    <= '0;
      frame_size  <= '0;
      bytes_left  <= '0;
      frame_index <= '0;
      status      <= ST_PENDING;
    end else if (accept) begin
      phase       <= phase_next;
      fbc         <= fbc_next;
      header_ok   <= header_ok_next;
      flags_seen  <= flags_seen_next;
      ver         <= ver_next;
      tag_size    <= tag_size_next;
      consumed    <= consumed_next;
      frame_size  <= frame_size_next;
      bytes_left  <= bytes_left_next;
      frame_index <= frame_index_next;
      status      <= status_next;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {6'd0, frame_index_next, frame_size_next, tag_size_next,
                  ver_next, status_next, role};
      m_tlast <= fend;
    end
  end

endmodule

`default_nettype wire

>>> tb/id3v2_tag_stream_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3v2_tag_stream_parser_top_tb
// Streams file bytes through the ID3v2 parser. A behavioural parser in the
// bench predicts every result beat, and each one is compared field by field.
// Traffic is good tags (v3 and other majors, padding, early tag end), cut
// streams, broken headers and noise.
// Source and sink pacing moves through several gap and stall mixes.
// ----------------------------------------------------------------------------

module id3v2_tag_stream_parser_top_tb;
  import id3tsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_BEATS   = 850;
  localparam int MAX_REPORTS    = 100;

  typedef enum logic [1:0] {PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_t;

  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       hold;
    pace_t      pace;
  } stream_beat_t;

  typedef struct packed {
    logic [2:0]  role;
    logic [2:0]  status;
    logic [7:0]  major;
    logic [27:0] tag_len;
    logic [31:0] frame_len;
    logic [15:0] frame_num;
    logic        frame_end;
  } byte_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_IN_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic                   m_tlast;

  stream_beat_t pending_beats[$];
  byte_result_t expected_results[$];
  logic [7:0]   file_bytes[$];
  pace_t        gen_pace = PACE_FULL;
  pace_t        run_pace = PACE_FULL;
  logic         hold_next = 1'b0;
  int           err_count = 0;
  int           idle_cycles = 0;

  // predicted parser state
  logic [2:0]  ps_phase;
  logic [3:0]  ps_count;
  logic        ps_hdr_ok;
  logic        ps_flags_seen;
  logic [7:0]  ps_major;
  logic [27:0] ps_tag_size;
  logic [32:0] ps_consumed;
  logic [31:0] ps_frame_size;
  logic [31:0] ps_frame_left;
  logic [15:0] ps_frame_idx;
  logic [2:0]  ps_status;

  id3v2_tag_stream_parser_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void reset_parser();
    ps_phase      = ROLE_HDR;
    ps_count      = '0;
    ps_hdr_ok     = 1'b1;
    ps_flags_seen = 1'b0;
    ps_major      = '0;
    ps_tag_size   = '0;
    ps_consumed   = '0;
    ps_frame_size = '0;
    ps_frame_left = '0;
    ps_frame_idx  = '0;
    ps_status     = ST_PENDING;
  endfunction

  function automatic void count_tag_byte();
    if (ps_consumed != '1) ps_consumed = ps_consumed + 1'b1;
  endfunction

  function automatic logic close_frame();
    if (ps_consumed < {5'd0, ps_tag_size}) begin
      ps_phase = ROLE_FID;
      ps_count = '0;
    end else begin
      ps_status = ST_VALID;
      ps_phase  = ROLE_OUT;
    end
    return 1'b1;
  endfunction

  function automatic logic open_frame_data();
    if (ps_frame_size == 0) return close_frame();
    ps_frame_left = ps_frame_size;
    ps_phase      = ROLE_FDATA;
    return 1'b0;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic first, input logic last);
    byte_result_t r;
    logic [3:0]   c;
    logic [3:0]   fld_len;
    logic [3:0]   hdr_len;
    logic         fend;
    if (first) reset_parser();
    fld_len = (ps_major == VER_V3) ? LEN_V3_FIELD : LEN_V2_FIELD;
    hdr_len = (ps_major == VER_V3) ? LEN_V3_FHDR : LEN_V2_FHDR;
    r       = '0;
    r.role  = ps_phase;
    c       = ps_count;
    fend    = 1'b0;
    case (ps_phase)
      ROLE_HDR: begin
        if ((c == HB_I && b != MAGIC_I) || (c == HB_D && b != MAGIC_D) ||
            (c == HB_3 && b != MAGIC_3)) ps_hdr_ok = 1'b0;
        if ((c == HB_MAJOR || c == HB_MINOR) && b >= VER_BAD) ps_hdr_ok = 1'b0;
        if (c == HB_MAJOR) ps_major = b;
        if (c == HB_FLAGS) ps_flags_seen = (b != 8'd0);
        if (c >= HB_SIZE0) begin
          if (b >= SYNCSAFE_LIM) ps_hdr_ok = 1'b0;
          ps_tag_size = {ps_tag_size[20:0], 7'd0} + {20'd0, b};
        end
        ps_count = c + 1'b1;
        if (c >= HB_LAST) begin
          if (!ps_hdr_ok) begin
            ps_status = ST_NOTAG;
            ps_phase  = ROLE_OUT;
          end else if (ps_flags_seen) begin
            ps_status = ST_FLAGS;
            ps_phase  = ROLE_OUT;
          end else begin
            ps_consumed   = '0;
            ps_frame_size = '0;
            if (ps_tag_size == 0) begin
              ps_status = ST_VALID;
              ps_phase  = ROLE_OUT;
            end else begin
              ps_phase = ROLE_FID;
              ps_count = '0;
            end
          end
        end
      end
      ROLE_FID: begin
        if (c == 0 && b == 8'd0) begin
          r.role   = ROLE_BLANK;
          ps_phase = ROLE_BLANK;
          ps_count = 4'd1;
        end else begin
          if (c == 0) begin
            if (ps_consumed != 0 && ps_frame_idx != 16'hFFFF) ps_frame_idx = ps_frame_idx + 1'b1;
            ps_frame_size = '0;
          end
          count_tag_byte();
          ps_count = c + 1'b1;
          if (ps_count >= fld_len) begin
            ps_phase = ROLE_FSIZE;
            ps_count = '0;
          end
        end
      end
      ROLE_BLANK: begin
        ps_count = c + 1'b1;
        if (ps_count >= hdr_len) begin
          ps_status = ST_VALID;
          ps_phase  = ROLE_OUT;
        end
      end
      ROLE_FSIZE: begin
        count_tag_byte();
        ps_frame_size = {ps_frame_size[23:0], b};
        ps_count      = c + 1'b1;
        if (ps_count >= fld_len) begin
          ps_count = '0;
          if (ps_major == VER_V3) ps_phase = ROLE_FFLAGS;
          else fend = open_frame_data();
        end
      end
      ROLE_FFLAGS: begin
        count_tag_byte();
        ps_count = c + 1'b1;
        if (ps_count >= LEN_FFLAGS) begin
          ps_count = '0;
          fend     = open_frame_data();
        end
      end
      ROLE_FDATA: begin
        count_tag_byte();
        if (ps_frame_left != 0) ps_frame_left = ps_frame_left - 1'b1;
        if (ps_frame_left == 0) fend = close_frame();
      end
      default: begin
        r.role   = ROLE_OUT;
        ps_phase = ROLE_OUT;
      end
    endcase
    if (last) begin
      if (ps_status == ST_PENDING) ps_status = ST_TRUNC;
      ps_phase = ROLE_OUT;
    end
    r.status    = ps_status;
    r.major     = ps_major;
    r.tag_len   = ps_tag_size;
    r.frame_len = ps_frame_size;
    r.frame_num = ps_frame_idx;
    r.frame_end = fend;
    expected_results.push_back(r);
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic push_beat(input logic [7:0] b, input logic first, input logic last);
    stream_beat_t sb;
    sb.data  = b;
    sb.first = first;
    sb.last  = last;
    sb.hold  = hold_next;
    sb.pace  = gen_pace;
    hold_next = 1'b0;
    pending_beats.push_back(sb);
  endtask

  // last_at < 0: no last flag in this file
  task automatic emit_file(input logic with_first, input int last_at);
    for (int i = 0; i < file_bytes.size(); i++)
      push_beat(file_bytes[i], with_first && i == 0, i == last_at);
    file_bytes.delete();
  endtask

  task automatic prepend_header(input logic [7:0] major, input logic [7:0] minor,
                                input logic [7:0] flags, input logic [27:0] size);
    file_bytes.push_front({1'b0, size[6:0]});
    file_bytes.push_front({1'b0, size[13:7]});
    file_bytes.push_front({1'b0, size[20:14]});
    file_bytes.push_front({1'b0, size[27:21]});
    file_bytes.push_front(flags);
    file_bytes.push_front(minor);
    file_bytes.push_front(major);
    file_bytes.push_front(MAGIC_3);
    file_bytes.push_front(MAGIC_D);
    file_bytes.push_front(MAGIC_I);
  endtask

  // well-formed tag with random frames; optionally cut short
  task automatic put_tag(input logic cut);
    logic [7:0]  major;
    logic        v3;
    int          fld;
    int          hl;
    int          body;
    int          dlen;
    int          pick;
    logic [31:0] fsz;
    logic [27:0] tsize;
    pick  = $urandom_range(0, 3);
    major = (pick < 2) ? VER_V3 : (pick == 2) ? 8'd4 : 8'($urandom_range(0, 254));
    v3    = (major == VER_V3);
    fld   = v3 ? 4 : 3;
    hl    = v3 ? 10 : 6;
    repeat ($urandom_range(0, 4)) begin
      dlen = $urandom_range(0, 6);
      fsz  = dlen;
      if ($urandom_range(0, 9) == 0) fsz = v3 ? $urandom : {8'd0, 24'($urandom)};
      file_bytes.push_back(8'($urandom_range(1, 255)));
      repeat (fld - 1) file_bytes.push_back(8'($urandom));
      for (int i = fld - 1; i >= 0; i--) file_bytes.push_back(fsz[8*i +: 8]);
      if (v3) repeat (2) file_bytes.push_back(8'($urandom));
      repeat (dlen) file_bytes.push_back(8'($urandom));
    end
    body = file_bytes.size();
    case ($urandom_range(0, 2))
      0: tsize = 28'(body);
      1: begin
        // padding, so a blank frame closes the tag
        tsize = 28'(body + hl + $urandom_range(0, 8));
        repeat (tsize - body + $urandom_range(0, 3)) file_bytes.push_back(8'd0);
      end
      default: tsize = (body == 0) ? 28'd0 : 28'($urandom_range(1, body));
    endcase
    prepend_header(major, 8'($urandom_range(0, 254)), 8'd0, tsize);
    repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
    if (cut) emit_file(1'b1, $urandom_range(0, file_bytes.size() - 1));
    else emit_file(1'b1, ($urandom_range(0, 4) == 0) ? -1 : file_bytes.size() - 1);
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : drive
    stream_beat_t nb;
    int           idle_pct;
    if (rst) begin
      s_tvalid <= 1'b0;
      reset_parser();
    end else begin
      if (s_tvalid && s_tready) parse_byte(s_tdata, s_tuser, s_tlast);
      if (!s_tvalid || s_tready) begin
        idle_pct = 0;
        if (pending_beats.size() != 0)
          idle_pct = (pending_beats[0].pace == PACE_SRC_IDLE) ? 85 :
                     (pending_beats[0].pace == PACE_BOTH) ? 26 : 0;
        if (pending_beats.size() != 0 &&
            !(pending_beats[0].hold && expected_results.size() != 0) &&
            $urandom_range(0, 99) >= idle_pct) begin
          nb = pending_beats.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nb.data;
          s_tuser  <= nb.first;
          s_tlast  <= nb.last;
          run_pace <= nb.pace;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : observe
    byte_result_t want;
    int           stall_pct;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: unexpected beat, expected none, actual %h", $time, m_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("byte_role", want.role, m_tdata[2:0]);
          check_field("tag_status", want.status, m_tdata[5:3]);
          check_field("major_version", want.major, m_tdata[13:6]);
          check_field("tag_length", want.tag_len, m_tdata[41:14]);
          check_field("frame_length", want.frame_len, m_tdata[73:42]);
          check_field("frame_number", want.frame_num, m_tdata[89:74]);
          check_field("frame_end", want.frame_end, m_tlast);
        end
      end
      stall_pct = (run_pace == PACE_SNK_STALL) ? 85 : (run_pace == PACE_BOTH) ? 26 : 0;
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- sequence
  initial begin : stimulus
    int file_no;
    int kind;
    int pos;

    // first file without a first flag, zero tag size
    prepend_header(VER_V3, 8'd0, 8'd0, 28'd0);
    file_bytes.push_back(8'hFF);
    emit_file(1'b0, 10);
    // stream ends inside the header, minor version out of range
    file_bytes = '{MAGIC_I, MAGIC_D, MAGIC_3, 8'hFE, VER_BAD};
    emit_file(1'b1, 4);
    // flags set, tag size 0x0FFFFFF
    prepend_header(8'd2, 8'd0, 8'h80, 28'h0FF_FFFF);
    emit_file(1'b1, 9);

    file_no = 0;
    while (pending_beats.size() < RANDOM_BEATS) begin
      gen_pace  = pace_t'((file_no / 4) % 4);
      hold_next = (file_no % 10 == 5);
      kind      = $urandom_range(0, 99);
      if (kind < 60) begin
        put_tag(1'b0);
      end else if (kind < 75) begin
        put_tag(1'b1);
      end else if (kind < 90) begin
        prepend_header(8'($urandom_range(0, 254)), 8'($urandom_range(0, 254)), 8'd0,
                       28'($urandom_range(0, 40)));
        pos = $urandom_range(0, 9);
        file_bytes[pos] = $urandom_range(0, 1) ? 8'hFF : 8'($urandom);
        if ($urandom_range(0, 1)) file_bytes[HB_FLAGS] = 8'($urandom_range(1, 255));
        repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom));
        emit_file(1'b1, $urandom_range(0, 1) ? file_bytes.size() - 1 : -1);
      end else begin
        repeat ($urandom_range(1, 12))
          push_beat(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
      end
      file_no++;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (pending_beats.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
